FILE: sv/gb3_pkg.sv
// gb3_pkg: shared constants, types and helpers for the 3x3 clamped-edge blur.
// Used by gb3_frame_ram, gb3_mac and gauss_blur_3x3_clamped_edge_top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gb3_pkg;

   // Frame store geometry
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(DEPTH);

   // Field widths of the stream payloads
   localparam int IN_COORD_W = 6;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int CFG_SPAN_W = 7;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CENTER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_EDGE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CORNER = 3'd4;

   localparam logic [CFG_SPAN_W-1:0] RST_FRAME_ROWS  = 7'd64;
   localparam logic [CFG_SPAN_W-1:0] RST_FRAME_COLS  = 7'd64;
   localparam logic [COEF_W-1:0]     RST_COEF_CENTER = 16'd13381;
   localparam logic [COEF_W-1:0]     RST_COEF_EDGE   = 16'd8116;
   localparam logic [COEF_W-1:0]     RST_COEF_CORNER = 16'd4922;

   // Command carried in tuser
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Nine-tap sum: 9 * 255 * 65535 fits in PIX_W + COEF_W + 4 bits
   localparam int ACC_W  = PIX_W + COEF_W + 4;
   localparam int PROD_W = PIX_W + COEF_W;
   localparam int RES_W  = ACC_W - FRAC_W;

   // Common width for coordinate / span compares
   localparam int RC_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
   localparam int RC1_W  = RC_W + 1;
   localparam int FLD_W  = (CFG_SPAN_W > IN_COORD_W) ? CFG_SPAN_W : IN_COORD_W;
   localparam int CMP_W  = (RC1_W > FLD_W) ? RC1_W : FLD_W;

   // Neighbor offset codes
   localparam logic [1:0] TAP_MINUS = 2'd0;
   localparam logic [1:0] TAP_ZERO  = 2'd1;
   localparam logic [1:0] TAP_PLUS  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic clear;       // zero the accumulator
      logic sample_vld;  // pixel/weight pair present this cycle
   } mac_ctl_type;

   // Last index in use: span of 0 acts as 1, above limit acts as limit
   function automatic logic [CMP_W-1:0] last_index(input logic [CFG_SPAN_W-1:0] span,
                                                   input logic [CMP_W-1:0] limit);
      logic [CMP_W-1:0] s;
      s = CMP_W'(span);
      if (s == '0)
         s = CMP_W'(1);
      if (s > limit)
         s = limit;
      return s - CMP_W'(1);
   endfunction

   // Neighbor coordinate, clamped into 0..last
   function automatic logic [CMP_W-1:0] step_coord(input logic [CMP_W-1:0] base,
                                                   input logic [1:0] tap,
                                                   input logic [CMP_W-1:0] last);
      logic [CMP_W-1:0] v;
      v = base;
      case (tap)
         TAP_MINUS: v = (base == '0) ? '0 : base - CMP_W'(1);
         TAP_PLUS:  v = (base >= last) ? last : base + CMP_W'(1);
         default:   v = base;
      endcase
      return v;
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
   endfunction

endpackage

`default_nettype wire

FILE: sv/gb3_frame_ram.sv
// gb3_frame_ram: single-port frame store, one write or one read per cycle.
// Read data is registered. Depends on gb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gb3_frame_ram (
   input  wire logic                        clock,
   input  wire logic                        we,
   input  wire logic [gb3_pkg::ADDR_W-1:0]  addr,
   input  wire logic [gb3_pkg::PIX_W-1:0]   wdata,
   output logic      [gb3_pkg::PIX_W-1:0]   rdata
);

   logic [gb3_pkg::PIX_W-1:0] mem [gb3_pkg::DEPTH];
   logic [gb3_pkg::PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/gb3_mac.sv
// gb3_mac: shared multiply-accumulate unit, one pixel * weight per cycle.
// Product is registered before the add. Depends on gb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gb3_mac (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gb3_pkg::mac_ctl_type          ctl,
   input  wire logic [gb3_pkg::PIX_W-1:0]     pixel,
   input  wire logic [gb3_pkg::COEF_W-1:0]    weight,
   output logic      [gb3_pkg::ACC_W-1:0]     acc,
   output logic                               busy
);

   logic [gb3_pkg::PROD_W-1:0] prod_ff;
   logic                       prod_vld_ff, prod_vld_in;
   logic [gb3_pkg::ACC_W-1:0]  acc_ff, acc_in;

   assign prod_vld_in = ctl.sample_vld;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear)
         acc_in = '0;
      else if (prod_vld_ff)
         acc_in = acc_ff + gb3_pkg::ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= gb3_pkg::PROD_W'(pixel) * gb3_pkg::PROD_W'(weight);
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_vld_ff;

endmodule

`default_nettype wire

FILE: sv/gauss_blur_3x3_clamped_edge_top.sv
// gauss_blur_3x3_clamped_edge_top: 3x3 Gaussian blur over a stored frame.
// Pixel write: accepted back to back. Query: nine single-port store reads, then the MAC
// product/accumulate stages, then the registered result (rsp_tvalid); the drain also waits
// for any earlier result to be taken. The next item is accepted in the cycle the result appears.
// Reset (synchronous) restores the registers, clears control; frame store unset.
// Depends on gb3_pkg, gb3_frame_ram, gb3_mac.
`timescale 1ns / 1ps
`default_nettype none

module gauss_blur_3x3_clamped_edge_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [gb3_pkg::REQ_DATA_W-1:0]     req_tdata,  // row[5:0], col[11:6], pixel[19:12]
   input  wire logic                               req_tuser,  // cmd
   // response stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [gb3_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // filtered_pixel[7:0]
   // configuration
   input  wire logic                               csr_we,
   input  wire logic [gb3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [gb3_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CMP_W = gb3_pkg::CMP_W;

   // configuration registers
   logic [gb3_pkg::CFG_SPAN_W-1:0] frame_rows_ff, frame_cols_ff;
   logic [gb3_pkg::COEF_W-1:0]     coef_center_ff, coef_edge_ff, coef_corner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff  <= gb3_pkg::RST_FRAME_ROWS;
         frame_cols_ff  <= gb3_pkg::RST_FRAME_COLS;
         coef_center_ff <= gb3_pkg::RST_COEF_CENTER;
         coef_edge_ff   <= gb3_pkg::RST_COEF_EDGE;
         coef_corner_ff <= gb3_pkg::RST_COEF_CORNER;
      end else if (csr_we) begin
         case (csr_index)
            gb3_pkg::CSR_FRAME_ROWS:  frame_rows_ff  <= csr_wdata[gb3_pkg::CFG_SPAN_W-1:0];
            gb3_pkg::CSR_FRAME_COLS:  frame_cols_ff  <= csr_wdata[gb3_pkg::CFG_SPAN_W-1:0];
            gb3_pkg::CSR_COEF_CENTER: coef_center_ff <= csr_wdata;
            gb3_pkg::CSR_COEF_EDGE:   coef_edge_ff   <= csr_wdata;
            gb3_pkg::CSR_COEF_CORNER: coef_corner_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request fields
   logic                          in_cmd;
   logic [gb3_pkg::IN_COORD_W-1:0] in_row, in_col;
   logic [gb3_pkg::PIX_W-1:0]     in_pixel;

   assign in_cmd   = req_tuser;
   assign in_row   = req_tdata[5:0];
   assign in_col   = req_tdata[11:6];
   assign in_pixel = req_tdata[19:12];

   // frame extent in use; the user must keep it static while a query runs, the block does not enforce it
   logic [CMP_W-1:0] last_r, last_c;
   assign last_r = gb3_pkg::last_index(frame_rows_ff, CMP_W'(gb3_pkg::MAX_ROWS));
   assign last_c = gb3_pkg::last_index(frame_cols_ff, CMP_W'(gb3_pkg::MAX_COLS));

   logic [CMP_W-1:0] in_row_x, in_col_x, q_row_x, q_col_x;
   assign in_row_x = CMP_W'(in_row);
   assign in_col_x = CMP_W'(in_col);
   assign q_row_x  = (in_row_x > last_r) ? last_r : in_row_x;
   assign q_col_x  = (in_col_x > last_c) ? last_c : in_col_x;

   logic wr_in_store;
   assign wr_in_store = (in_row_x < CMP_W'(gb3_pkg::MAX_ROWS)) &&
                        (in_col_x < CMP_W'(gb3_pkg::MAX_COLS));

   // sequencer
   gb3_pkg::state_type state_ff, state_in;
   logic [gb3_pkg::ROW_W-1:0] row_ff;
   logic [gb3_pkg::COL_W-1:0] col_ff;
   logic [1:0]                tap_r_ff, tap_r_in, tap_c_ff, tap_c_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [gb3_pkg::COEF_W-1:0] weight_ff, weight_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [gb3_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_fire, query_start, wr_fire, issue, last_tap, load_rsp, mac_busy;
   logic [gb3_pkg::ACC_W-1:0] acc;

   assign req_fire    = req_tvalid && req_tready;
   assign query_start = req_fire && (in_cmd == gb3_pkg::CMD_QUERY);
   assign wr_fire     = req_fire && (in_cmd == gb3_pkg::CMD_WRITE) && wr_in_store;
   assign last_tap    = (tap_r_ff == gb3_pkg::TAP_PLUS) && (tap_c_ff == gb3_pkg::TAP_PLUS);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gb3_pkg::ST_IDLE:  if (query_start) state_in = gb3_pkg::ST_SCAN;
         gb3_pkg::ST_SCAN:  if (last_tap) state_in = gb3_pkg::ST_DRAIN;
         gb3_pkg::ST_DRAIN: if (!rd_vld_ff && !mac_busy && !rsp_valid_ff)
                               state_in = gb3_pkg::ST_IDLE;
         default:           state_in = gb3_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         gb3_pkg::ST_IDLE:  req_tready = 1'b1;
         gb3_pkg::ST_SCAN:  issue = 1'b1;
         gb3_pkg::ST_DRAIN: load_rsp = !rd_vld_ff && !mac_busy && !rsp_valid_ff;
         default: ;
      endcase
   end

   // tap walk: column offset fastest, row offset slowest
   always_comb begin
      tap_r_in = tap_r_ff;
      tap_c_in = tap_c_ff;
      if (query_start) begin
         tap_r_in = gb3_pkg::TAP_MINUS;
         tap_c_in = gb3_pkg::TAP_MINUS;
      end else if (issue) begin
         if (tap_c_ff == gb3_pkg::TAP_PLUS) begin
            tap_c_in = gb3_pkg::TAP_MINUS;
            tap_r_in = tap_r_ff + 2'd1;
         end else begin
            tap_c_in = tap_c_ff + 2'd1;
         end
      end
   end

   // weight class of the tap being issued
   always_comb begin
      if (tap_r_ff == gb3_pkg::TAP_ZERO && tap_c_ff == gb3_pkg::TAP_ZERO)
         weight_in = coef_center_ff;
      else if (tap_r_ff == gb3_pkg::TAP_ZERO || tap_c_ff == gb3_pkg::TAP_ZERO)
         weight_in = coef_edge_ff;
      else
         weight_in = coef_corner_ff;
   end

   assign rd_vld_in = issue;

   // neighbor address
   logic [CMP_W-1:0]           nb_row_x, nb_col_x;
   logic [gb3_pkg::ADDR_W-1:0] rd_addr, wr_addr, ram_addr;
   assign nb_row_x = gb3_pkg::step_coord(CMP_W'(row_ff), tap_r_ff, last_r);
   assign nb_col_x = gb3_pkg::step_coord(CMP_W'(col_ff), tap_c_ff, last_c);
   assign rd_addr  = gb3_pkg::store_addr(nb_row_x[gb3_pkg::ROW_W-1:0],
                                         nb_col_x[gb3_pkg::COL_W-1:0]);
   assign wr_addr  = gb3_pkg::store_addr(in_row_x[gb3_pkg::ROW_W-1:0],
                                         in_col_x[gb3_pkg::COL_W-1:0]);
   assign ram_addr = wr_fire ? wr_addr : rd_addr;

   // result: truncate the Q12.16 sum, saturate at 255
   logic [gb3_pkg::RES_W-1:0] acc_int;
   assign acc_int = acc[gb3_pkg::ACC_W-1:gb3_pkg::FRAC_W];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (acc_int > gb3_pkg::RES_W'(255)) ?
                        gb3_pkg::RSP_DATA_W'(255) : acc_int[gb3_pkg::RSP_DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gb3_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_r_ff     <= gb3_pkg::TAP_MINUS;
         tap_c_ff     <= gb3_pkg::TAP_MINUS;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_r_ff     <= tap_r_in;
         tap_c_ff     <= tap_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (query_start) begin
         row_ff <= q_row_x[gb3_pkg::ROW_W-1:0];
         col_ff <= q_col_x[gb3_pkg::COL_W-1:0];
      end
      weight_ff   <= weight_in;
      rsp_data_ff <= rsp_data_in;
   end

   // frame store and shared MAC
   logic [gb3_pkg::PIX_W-1:0] ram_rdata;

   gb3_frame_ram u_ram (
      .clock (clock),
      .we    (wr_fire),
      .addr  (ram_addr),
      .wdata (in_pixel),
      .rdata (ram_rdata)
   );

   gb3_pkg::mac_ctl_type mac_ctl;
   assign mac_ctl.clear      = query_start;
   assign mac_ctl.sample_vld = rd_vld_ff;

   gb3_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .pixel  (ram_rdata),
      .weight (weight_ff),
      .acc    (acc),
      .busy   (mac_busy)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: dv/gauss_blur_3x3_clamped_edge_top_tb.sv
// gauss_blur_3x3_clamped_edge_top_tb: self-checking bench for the 3x3 clamped-edge blur.
// Drives pixel writes, filter queries and register writes. A scoreboard class predicts every
// filtered value. Depends on gb3_pkg and gauss_blur_3x3_clamped_edge_top.
`timescale 1ns / 1ps

class blur_scoreboard;
   logic [gb3_pkg::PIX_W-1:0]      pix_mem [gb3_pkg::DEPTH];
   logic [gb3_pkg::CFG_SPAN_W-1:0] rows_cfg;
   logic [gb3_pkg::CFG_SPAN_W-1:0] cols_cfg;
   logic [gb3_pkg::COEF_W-1:0]     wt_center;
   logic [gb3_pkg::COEF_W-1:0]     wt_edge;
   logic [gb3_pkg::COEF_W-1:0]     wt_corner;
   logic [gb3_pkg::PIX_W-1:0]      blur_q [$];
   int                             mismatches;

   function new();
      rows_cfg   = gb3_pkg::RST_FRAME_ROWS;
      cols_cfg   = gb3_pkg::RST_FRAME_COLS;
      wt_center  = gb3_pkg::RST_COEF_CENTER;
      wt_edge    = gb3_pkg::RST_COEF_EDGE;
      wt_corner  = gb3_pkg::RST_COEF_CORNER;
      mismatches = 0;
      foreach (pix_mem[i]) pix_mem[i] = '0;
   endfunction

   function void set_reg(logic [gb3_pkg::CSR_IDX_W-1:0] idx, logic [gb3_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         gb3_pkg::CSR_FRAME_ROWS:  rows_cfg  = val[gb3_pkg::CFG_SPAN_W-1:0];
         gb3_pkg::CSR_FRAME_COLS:  cols_cfg  = val[gb3_pkg::CFG_SPAN_W-1:0];
         gb3_pkg::CSR_COEF_CENTER: wt_center = val;
         gb3_pkg::CSR_COEF_EDGE:   wt_edge   = val;
         gb3_pkg::CSR_COEF_CORNER: wt_corner = val;
         default: ;
      endcase
   endfunction

   // last index in use; 0 behaves as 1, oversize as the store limit
   function int span_last(logic [gb3_pkg::CFG_SPAN_W-1:0] span, int limit);
      int s;
      s = span;
      if (s == 0) s = 1;
      if (s > limit) s = limit;
      return s - 1;
   endfunction

   function int clamp_to(int v, int last);
      return (v > last) ? last : v;
   endfunction

   function int tap(int base, int d, int last);
      if (d < 0) return (base == 0) ? 0 : base - 1;
      if (d > 0) return (base >= last) ? last : base + 1;
      return base;
   endfunction

   function logic [gb3_pkg::PIX_W-1:0] filtered_at(int row, int col);
      int                         lr, lc, r0, c0;
      longint                     acc;
      logic [gb3_pkg::COEF_W-1:0] w;
      lr  = span_last(rows_cfg, gb3_pkg::MAX_ROWS);
      lc  = span_last(cols_cfg, gb3_pkg::MAX_COLS);
      r0  = clamp_to(row, lr);
      c0  = clamp_to(col, lc);
      acc = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0)
               w = wt_center;
            else if (dr == 0 || dc == 0)
               w = wt_edge;
            else
               w = wt_corner;
            acc += longint'(pix_mem[tap(r0, dr, lr) * gb3_pkg::MAX_COLS + tap(c0, dc, lc)])
                   * longint'(w);
         end
      end
      acc = acc >> gb3_pkg::FRAC_W;
      return (acc > 255) ? 8'd255 : acc[7:0];
   endfunction

   function void note_request(logic cmd, logic [5:0] row, logic [5:0] col, logic [7:0] pix);
      if (cmd == gb3_pkg::CMD_WRITE)
         pix_mem[int'(row) * gb3_pkg::MAX_COLS + int'(col)] = pix;
      else
         blur_q.push_back(filtered_at(row, col));
   endfunction

   function void check_result(logic [gb3_pkg::RSP_DATA_W-1:0] got);
      logic [gb3_pkg::PIX_W-1:0] exp_pix;
      if (blur_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response transaction: filtered_pixel %0d", got);
         return;
      end
      exp_pix = blur_q.pop_front();
      if (got !== exp_pix) begin
         mismatches++;
         if (mismatches <= 10)
            $display("filtered_pixel mismatch: expected %0d, got %0d", exp_pix, got);
      end
   endfunction

   function int pending();
      return blur_q.size();
   endfunction
endclass

module gauss_blur_3x3_clamped_edge_top_tb;

   localparam int LONG_HOLD      = 120;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 88;
   localparam logic [gb3_pkg::CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [gb3_pkg::CSR_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [gb3_pkg::REQ_DATA_W-1:0]    req_tdata = '0;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [gb3_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                              csr_we = 1'b0;
   logic [gb3_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [gb3_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   blur_scoreboard sb;
   bit             pix_written [gb3_pkg::DEPTH];
   bit             tail_quiet = 1'b0;
   bit             hold_pending = 1'b0;
   bit             req_calm = 1'b0;
   bit             rsp_calm = 1'b0;
   int             items_sent = 0;

   always #6 clock = ~clock;

   gauss_blur_3x3_clamped_edge_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // transaction monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[5:0], req_tdata[11:6], req_tdata[19:12]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   // watchdog: cycles without any transaction
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // response side backpressure
   initial begin
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
         if (hold_pending) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_pending = 1'b0;
         end else if (!tail_quiet && !rsp_calm && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // returns just after the accepting edge with tvalid still high
   task automatic send_item(logic cmd, logic [5:0] row, logic [5:0] col, logic [7:0] pix);
      @(negedge clock);
      if ($urandom_range(0, 23) == 0) req_calm = !req_calm;
      if (!tail_quiet && !req_calm && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {4'b0, pix, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_pixel(int r, int c, int p);
      pix_written[r * gb3_pkg::MAX_COLS + c] = 1'b1;
      send_item(gb3_pkg::CMD_WRITE, 6'(r), 6'(c), 8'(p));
   endtask

   // fill any unwritten neighbor first (fill < 0: random values), then query
   task automatic query_at(int row, int col, int fill);
      int lr, lc, r0, c0, r, c;
      lr = sb.span_last(sb.rows_cfg, gb3_pkg::MAX_ROWS);
      lc = sb.span_last(sb.cols_cfg, gb3_pkg::MAX_COLS);
      r0 = sb.clamp_to(row, lr);
      c0 = sb.clamp_to(col, lc);
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            r = sb.tap(r0, dr, lr);
            c = sb.tap(c0, dc, lc);
            if (!pix_written[r * gb3_pkg::MAX_COLS + c])
               write_pixel(r, c, (fill < 0) ? $urandom_range(0, 255) : fill);
         end
      end
      send_item(gb3_pkg::CMD_QUERY, 6'(row), 6'(col), 8'($urandom));
   endtask

   // drop tvalid, wait for every outstanding result, let trailing writes retire
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // leaves csr_we high; callers lower it after the last write
   task automatic csr_write(logic [gb3_pkg::CSR_IDX_W-1:0] idx,
                            logic [gb3_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic program_regs(logic [6:0] rows, logic [6:0] cols,
                               logic [15:0] w_c, logic [15:0] w_e, logic [15:0] w_k);
      csr_write(gb3_pkg::CSR_FRAME_ROWS, 16'(rows));
      csr_write(gb3_pkg::CSR_FRAME_COLS, 16'(cols));
      csr_write(gb3_pkg::CSR_COEF_CENTER, w_c);
      csr_write(gb3_pkg::CSR_COEF_EDGE, w_e);
      csr_write(gb3_pkg::CSR_COEF_CORNER, w_k);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [6:0] pick_span();
      case ($urandom_range(0, 5))
         0:       return 7'd1;
         1:       return 7'd64;
         2:       return 7'($urandom_range(2, 8));
         3:       return $urandom_range(0, 1) ? 7'd127 : 7'd0;
         default: return 7'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 12000));
         1:       return 16'($urandom);
         2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 3000));
      endcase
   endfunction

   task automatic random_item();
      int pick, lr, lc;
      pick = $urandom_range(0, 9);
      lr   = sb.span_last(sb.rows_cfg, gb3_pkg::MAX_ROWS);
      lc   = sb.span_last(sb.cols_cfg, gb3_pkg::MAX_COLS);
      if (pick < 4)
         write_pixel($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      else if (pick < 8)
         query_at($urandom_range(0, lr), $urandom_range(0, lc), -1);
      else
         query_at($urandom_range(0, 63), $urandom_range(0, 63), -1);  // often off-frame
   endtask

   initial begin
      int  target, midpoint;
      bit  paused;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset registers: corners of the full frame and an interior point
      query_at(0, 0, 255);
      query_at(63, 63, 0);
      query_at(31, 32, -1);
      settle();

      // oversize/zero spans and full-scale weights: saturation
      program_regs(7'd0, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      csr_write(CSR_SPARE_FIRST, 16'h0001);
      csr_write(CSR_SPARE_LAST, 16'h0040);
      @(negedge clock);
      csr_we = 1'b0;
      query_at(63, 0, -1);
      query_at(0, 63, -1);
      settle();

      // 1x1 frame: all nine taps hit one pixel
      program_regs(7'd1, 7'd1, 16'h0000, 16'h0000, 16'h0000);
      query_at(40, 40, -1);
      settle();
      program_regs(7'd1, 7'd1, gb3_pkg::RST_COEF_CENTER, gb3_pkg::RST_COEF_EDGE,
                   gb3_pkg::RST_COEF_CORNER);
      query_at(0, 0, -1);

      paused = 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         if (ph == 5) begin
            tail_quiet = 1'b1;
            program_regs(7'd64, 7'd64, gb3_pkg::RST_COEF_CENTER, gb3_pkg::RST_COEF_EDGE,
                         gb3_pkg::RST_COEF_CORNER);
         end else begin
            program_regs(pick_span(), pick_span(), pick_weight(), pick_weight(),
                         pick_weight());
         end
         if (ph == 3) hold_pending = 1'b1;  // sender keeps offering during the hold
         target   = items_sent + PHASE_ITEMS;
         midpoint = items_sent + PHASE_ITEMS / 2;
         while (items_sent < target) begin
            random_item();
            if (ph == 2 && !paused && items_sent >= midpoint) begin
               paused = 1'b1;
               settle();
            end
         end
      end
      settle();

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: gauss_blur_3x3_clamped_edge_top.f
sv/gb3_pkg.sv
sv/gb3_frame_ram.sv
sv/gb3_mac.sv
sv/gauss_blur_3x3_clamped_edge_top.sv
dv/gauss_blur_3x3_clamped_edge_top_tb.sv
